// ----- sv/nntt_pkg.sv -----
// Package for the nearest neighbor track table: request kinds, field widths,
// result struct. No dependencies.
package nntt_pkg;

    localparam int unsigned CoordW = 24;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned DistW  = 23;
    localparam int unsigned AgeW   = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned SqW    = 50;

    typedef enum logic [1:0] {
        REQ_DET    = 2'd0,
        REQ_FRAME  = 2'd1,
        REQ_TARGET = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    localparam logic [CfgIdxW-1:0] CFG_MATCH_DIST = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_JUMP   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_AGE    = 2'd2;

    typedef struct packed {
        logic [5:0]        live_count;
        logic [23:0]       target_y;
        logic [23:0]       target_x;
        logic              target_moved;
        logic              dropped;
        logic              was_new;
        logic [4:0]        slot;
        logic [1:0]        kind;
    } t_result;

endpackage

// ----- sv/nearest_neighbor_track_table_top.sv -----
// Nearest neighbor track table top: entry memory, nearest-entry scan and age
// sweep, one request at a time. Depends on nntt_pkg and nntt_sqdist.
// After accept, a detection scans and decides; a frame end scans, moves the
// target and runs the age sweep over all entries; a set target goes to the result.
// Next request is taken the cycle after the result loads; a held result stalls.
// Reset (sync, active low) clears valid bits, target and config to defaults.
module nearest_neighbor_track_table_top #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // pos_x, pos_y, time_ms
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // slot,was_new,dropped,target_moved,target_x,target_y,live_count
    output logic [1:0]  m_axis_tuser,   // kind
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [22:0] i_cfg_data
);
    import nntt_pkg::*;

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_AGE   = 6'b001000,
        S_MOVE  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [DistW-1:0] r_match, r_jump;
    logic [AgeW-1:0]  r_age;
    logic signed [CoordW-1:0] r_tx, r_ty, r_px, r_py;
    logic [TimeW-1:0] r_now;
    t_req r_kind;
    logic [TABLE_DEPTH-1:0] r_valid;
    // per-request result flags, copied to the output register when done
    logic [4:0] r_slot;
    logic r_new, r_drop, r_moved;

    // entry memory: x, y, seen time
    logic [CoordW*2+TimeW-1:0] mem [TABLE_DEPTH];
    logic [CoordW*2+TimeW-1:0] r_rd;
    logic [IW-1:0] rd_addr;
    logic we;
    logic [IW-1:0] wr_addr;
    logic [CoordW*2+TimeW-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        r_rd <= mem[rd_addr];
    end

    // scan pipeline: issue address r_ia, read data in r_rd, then distance from nntt_sqdist
    logic [IW:0] r_ia;
    logic [IW:0] r_p1, r_p2, r_p3;   // slot index, extended by one msb
    logic r_v1, r_v2, r_v3;
    logic [SqW-1:0] sq;
    logic [SqW-1:0] r_bd;
    logic r_found;
    logic [IW-1:0] r_best;
    logic signed [CoordW-1:0] ex, ey, cx, cy;
    logic [TimeW-1:0] eseen;

    assign ex = r_rd[CoordW*2+TimeW-1 -: CoordW];
    assign ey = r_rd[CoordW+TimeW-1 -: CoordW];
    assign eseen = r_rd[TimeW-1:0];
    assign cx = (r_kind == REQ_DET) ? r_px : r_tx;
    assign cy = (r_kind == REQ_DET) ? r_py : r_ty;

    nntt_sqdist u_sq (.i_clk(i_clk), .i_ax(ex), .i_ay(ey), .i_bx(cx), .i_by(cy), .o_sq(sq));

    logic [2*DistW-1:0] r_gate;
    always_ff @(posedge i_clk) r_gate <= (r_kind == REQ_DET) ? r_match * r_match : r_jump * r_jump;

    // lowest free slot
    logic [IW-1:0] free_idx;
    logic free_any;
    always_comb begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    logic [CW-1:0] pop;
    always_comb begin
        pop = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) pop = pop + CW'(r_valid[i]);
    end

    t_result r_res;
    logic r_ov;

    assign s_axis_tready = (r_state == S_IDLE);
    wire acc = s_axis_tvalid && s_axis_tready;
    wire [IW:0] last_ia = (IW+1)'(TABLE_DEPTH);
    logic hit_ok;
    assign hit_ok = r_found && ((r_kind == REQ_DET) ? (r_bd <= SqW'(r_gate))
                                                    : (r_bd < SqW'(r_gate)));

    always_comb begin
        rd_addr = r_ia[IW-1:0];
        if (r_state == S_DEC) rd_addr = r_best;
        we = 1'b0;
        wr_addr = free_idx;
        wr_data = {r_px, r_py, r_now};
        if (r_state == S_DEC && r_kind == REQ_DET) begin
            if (hit_ok) begin we = 1'b1; wr_addr = r_best; end
            else if (free_any) we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_tx <= '0;
            r_ty <= '0;
            r_match <= 23'd614;
            r_jump <= 23'd1434;
            r_age <= 16'd1000;
            r_ov <= 1'b0;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0;
            r_found <= 1'b0;
            r_ia <= '0;
            r_kind <= REQ_DET;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MATCH_DIST: r_match <= i_cfg_data;
                    CFG_MAX_JUMP:   r_jump <= i_cfg_data;
                    CFG_MAX_AGE:    r_age <= i_cfg_data[AgeW-1:0];
                    default: ;
                endcase
            end
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            // scan pipe shifts every cycle
            r_v1 <= (r_state == S_SCAN) && (r_ia != last_ia) && r_valid[r_ia[IW-1:0]];
            r_p1 <= r_ia;
            r_v2 <= r_v1; r_p2 <= r_p1;
            r_v3 <= r_v2; r_p3 <= r_p2;
            if (r_v3 && (!r_found || sq <= r_bd)) begin
                r_found <= 1'b1;
                r_bd <= sq;
                r_best <= r_p3[IW-1:0];
            end
            unique case (r_state)
                S_IDLE: if (acc) begin
                    r_kind <= t_req'(s_axis_tuser);
                    r_px <= s_axis_tdata[23:0];
                    r_py <= s_axis_tdata[47:24];
                    r_now <= s_axis_tdata[79:48];
                    r_ia <= '0;
                    r_found <= 1'b0;
                    r_slot <= '0;
                    r_new <= 1'b0;
                    r_drop <= 1'b0;
                    r_moved <= 1'b0;
                    priority if (t_req'(s_axis_tuser) == REQ_TARGET) begin
                        r_tx <= s_axis_tdata[23:0];
                        r_ty <= s_axis_tdata[47:24];
                        r_state <= S_OUT;
                    end else if (t_req'(s_axis_tuser) == REQ_NONE) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_ia != last_ia) r_ia <= r_ia + (IW+1)'(1);
                    else if (!r_v1 && !r_v2 && !r_v3) r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_kind == REQ_DET) begin
                        if (hit_ok) r_slot <= 5'(r_best);
                        else if (free_any) begin
                            r_valid[free_idx] <= 1'b1;
                            r_slot <= 5'(free_idx);
                            r_new <= 1'b1;
                        end else r_drop <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MOVE;
                    end
                    r_ia <= '0;
                end
                S_MOVE: begin
                    // entry read issued in S_DEC
                    if (hit_ok) begin
                        r_tx <= ex;
                        r_ty <= ey;
                        r_moved <= 1'b1;
                    end
                    r_state <= S_AGE;
                end
                S_AGE: begin
                    // r_rd holds entry r_p1 (read the cycle before)
                    if (r_ia != last_ia) r_ia <= r_ia + (IW+1)'(1);
                    if (r_ia != '0 && (r_now - eseen) > TimeW'(r_age))
                        r_valid[r_p1[IW-1:0]] <= 1'b0;
                    if (r_ia == last_ia) r_state <= S_OUT;
                end
                S_OUT: if (!r_ov) begin
                    r_ov <= 1'b1;
                    r_res <= {6'(pop), r_ty, r_tx, r_moved, r_drop, r_new, r_slot, r_kind};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser = r_res.kind;
    assign m_axis_tdata = {2'd0, r_res.live_count, r_res.target_y, r_res.target_x,
                           r_res.target_moved, r_res.dropped, r_res.was_new, r_res.slot};

    // valid entries only appear from a detection decision
    a_new_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_valid) > $countones($past(r_valid))) |-> $past(r_state == S_DEC))
        else $error("valid bit set outside decision");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_ov) |=> r_ov)
        else $error("result lost");
endmodule

// ----- sv/nntt_sqdist.sv -----
// Pipelined squared distance between two Q12.12 points, two register stages.
// Depends on nntt_pkg.
module nntt_sqdist (
    input  logic                                  i_clk,
    input  logic signed [nntt_pkg::CoordW-1:0]    i_ax,
    input  logic signed [nntt_pkg::CoordW-1:0]    i_ay,
    input  logic signed [nntt_pkg::CoordW-1:0]    i_bx,
    input  logic signed [nntt_pkg::CoordW-1:0]    i_by,
    output logic        [nntt_pkg::SqW-1:0]       o_sq
);
    import nntt_pkg::*;

    logic signed [CoordW:0] n_dx, n_dy;
    logic [CoordW:0] n_ux, n_uy;
    // |d| is at most 2^24-1, for the extreme pair; kept at 25 bits
    logic [CoordW:0] r_ax, r_ay;

    always_comb begin
        n_dx = {i_ax[CoordW-1], i_ax} - {i_bx[CoordW-1], i_bx};
        n_dy = {i_ay[CoordW-1], i_ay} - {i_by[CoordW-1], i_by};
        n_ux = n_dx[CoordW] ? -n_dx : n_dx;
        n_uy = n_dy[CoordW] ? -n_dy : n_dy;
    end

    always_ff @(posedge i_clk) begin
        r_ax <= n_ux;
        r_ay <= n_uy;
        o_sq <= SqW'({25'd0, r_ax} * {25'd0, r_ax}) + SqW'({25'd0, r_ay} * {25'd0, r_ay});
    end
endmodule

// ----- tb/nntt_checker.sv -----
// Checker for the nearest neighbor track table: watches the request, result and
// configuration channels, predicts each result and compares. Depends on nntt_pkg.
`timescale 1ns / 1ps
module nntt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [22:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import nntt_pkg::*;

    localparam int Depth = 32;

    logic signed [23:0] tab_x [Depth];
    logic signed [23:0] tab_y [Depth];
    logic [31:0]        tab_seen [Depth];
    logic               tab_live [Depth];
    logic signed [23:0] tgt_x, tgt_y;
    logic [22:0]        gate_r, jump_r;
    logic [15:0]        age_r;
    t_result            expected_q [$];

    function automatic logic [49:0] dist2(logic signed [23:0] ax, logic signed [23:0] ay,
                                          logic signed [23:0] bx, logic signed [23:0] by);
        logic signed [24:0] dx, dy;
        logic [24:0] ux, uy;
        dx = 25'(ax) - 25'(bx);
        dy = 25'(ay) - 25'(by);
        ux = dx[24] ? -dx : dx;
        uy = dy[24] ? -dy : dy;
        return 50'(ux) * 50'(ux) + 50'(uy) * 50'(uy);
    endfunction

    function automatic int closest(logic signed [23:0] x, logic signed [23:0] y,
                                   output logic [49:0] bd);
        int best;
        logic [49:0] d;
        best = -1;
        bd = '0;
        for (int i = 0; i < Depth; i++) begin
            if (!tab_live[i]) continue;
            d = dist2(tab_x[i], tab_y[i], x, y);
            if (best < 0 || d <= bd) begin
                bd = d;
                best = i;
            end
        end
        return best;
    endfunction

    task automatic predict_request(t_req kind, logic signed [23:0] px,
                                   logic signed [23:0] py, logic [31:0] now);
        t_result r;
        logic [49:0] d;
        int hit, fr, n;
        r = '0;
        r.kind = kind;
        if (kind == REQ_DET) begin
            hit = closest(px, py, d);
            if (hit >= 0 && d <= 50'(gate_r) * 50'(gate_r)) begin
                tab_x[hit] = px; tab_y[hit] = py; tab_seen[hit] = now;
                r.slot = hit[4:0];
            end else begin
                fr = -1;
                for (int i = 0; i < Depth; i++)
                    if (!tab_live[i] && fr < 0) fr = i;
                if (fr >= 0) begin
                    tab_x[fr] = px; tab_y[fr] = py; tab_seen[fr] = now;
                    tab_live[fr] = 1'b1;
                    r.slot = fr[4:0];
                    r.was_new = 1'b1;
                end else begin
                    r.dropped = 1'b1;
                end
            end
        end else if (kind == REQ_FRAME) begin
            hit = closest(tgt_x, tgt_y, d);
            if (hit >= 0 && d < 50'(jump_r) * 50'(jump_r)) begin
                tgt_x = tab_x[hit];
                tgt_y = tab_y[hit];
                r.target_moved = 1'b1;
            end
            for (int i = 0; i < Depth; i++)
                if (tab_live[i] && (now - tab_seen[i]) > 32'(age_r)) tab_live[i] = 1'b0;
        end else begin
            tgt_x = px;
            tgt_y = py;
        end
        n = 0;
        for (int i = 0; i < Depth; i++) n += tab_live[i];
        r.target_x = tgt_x;
        r.target_y = tgt_y;
        r.live_count = n[5:0];
        expected_q = {expected_q, r};
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    t_result got, want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < Depth; i++) tab_live[i] = 1'b0;
            tgt_x = '0; tgt_y = '0;
            gate_r = 23'd614; jump_r = 23'd1434; age_r = 16'd1000;
            expected_q.delete();
            o_errors = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MATCH_DIST: gate_r = i_cfg_data;
                    CFG_MAX_JUMP:   jump_r = i_cfg_data;
                    CFG_MAX_AGE:    age_r = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                // tdata holds every field but kind, slot lowest; kind rides on tuser
                got = {m_axis_tdata[61:0], m_axis_tuser};
                if (expected_q.size() == 0) begin
                    report("unexpected result", m_axis_tdata, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.kind != want.kind) report("kind", got.kind, want.kind);
                    if (got.slot != want.slot) report("slot", got.slot, want.slot);
                    if (got.was_new != want.was_new) report("was_new", got.was_new, want.was_new);
                    if (got.dropped != want.dropped) report("dropped", got.dropped, want.dropped);
                    if (got.target_moved != want.target_moved)
                        report("target_moved", got.target_moved, want.target_moved);
                    if (got.target_x != want.target_x)
                        report("target_x", got.target_x, want.target_x);
                    if (got.target_y != want.target_y)
                        report("target_y", got.target_y, want.target_y);
                    if (got.live_count != want.live_count)
                        report("live_count", got.live_count, want.live_count);
                end
            end
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser != REQ_NONE)
                predict_request(t_req'(s_axis_tuser), s_axis_tdata[23:0],
                                s_axis_tdata[47:24], s_axis_tdata[79:48]);
            o_pending = expected_q.size();
        end
    end
endmodule

// ----- tb/nearest_neighbor_track_table_top_test.sv -----
// Top of the track table testbench: clock, reset, configuration phases and
// request stimulus with random gaps and stalls. Depends on nntt_pkg, nntt_checker.
`timescale 1ns / 1ps
module nearest_neighbor_track_table_top_test;
    import nntt_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = REQ_DET;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_MATCH_DIST;
    logic [22:0] i_cfg_data = '0;
    int          errors, pending;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    logic [31:0] now_ms = '0;

    localparam int WatchLimit = 20000;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    nearest_neighbor_track_table_top uut (.*);

    nntt_checker checker_i (.*, .o_errors(errors), .o_pending(pending));

    // receiver stall pattern, with long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (!i_cfg_we)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // valid stays high after a send until a gap or a drain takes it down
    task automatic send(t_req kind, logic [23:0] x, logic [23:0] y, logic [31:0] t);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {t, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
        if (n > 0) s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain_and_config(logic [22:0] gd, logic [22:0] jd, logic [15:0] ag);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_MATCH_DIST; i_cfg_data <= gd;
        @(negedge i_clk);
        i_cfg_idx <= CFG_MAX_JUMP; i_cfg_data <= jd;
        @(negedge i_clk);
        i_cfg_idx <= CFG_MAX_AGE; i_cfg_data <= 23'(ag);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random request near a small cluster so detections match and frame ends move
    task automatic random_request(int spread, int tstep);
        int r;
        logic [23:0] x, y;
        r = $urandom_range(0, 99);
        now_ms = now_ms + 32'($urandom_range(0, tstep));
        x = 24'($signed($urandom_range(0, 2 * spread)) - spread);
        y = 24'($signed($urandom_range(0, 2 * spread)) - spread);
        if (r < 3) begin
            x = 24'($urandom); y = 24'($urandom);
        end
        if (r < 70) send(REQ_DET, x, y, now_ms);
        else if (r < 88) send(REQ_FRAME, x, y, now_ms);
        else if (r < 96) send(REQ_TARGET, x, y, (r & 1) ? $urandom : now_ms);
        else send(REQ_NONE, x, y, $urandom);
        gap();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: extremes, ties, gate and jump boundaries, empty frame end
        send(REQ_FRAME, '0, '0, 32'd0);
        send(REQ_DET, 24'h7fffff, 24'h800000, 32'hffffffff);
        send(REQ_DET, 24'h800000, 24'h7fffff, 32'd0);
        send(REQ_DET, 24'd0, 24'd0, 32'd5);
        send(REQ_DET, 24'd614, 24'd0, 32'd6);
        send(REQ_DET, 24'd1229, 24'd0, 32'd7);
        send(REQ_DET, 24'd2000, 24'd0, 32'd8);
        send(REQ_DET, 24'd1000, 24'd0, 32'd9);
        send(REQ_TARGET, 24'd566, 24'd0, 32'd9);
        send(REQ_FRAME, '0, '0, 32'd10);
        send(REQ_TARGET, -24'sd1434, 24'd0, 32'd10);
        send(REQ_FRAME, '0, '0, 32'd1009);
        send(REQ_FRAME, '0, '0, 32'd1011);
        send(REQ_NONE, 24'hffffff, 24'hffffff, 32'hffffffff);
        send(REQ_TARGET, 24'h800000, 24'h7fffff, 32'd0);
        drain_and_config(23'h7fffff, 23'h7fffff, 16'hffff);
        send(REQ_DET, 24'h7fffff, 24'h7fffff, 32'd0);
        send(REQ_FRAME, '0, '0, 32'd0);
        drain_and_config(23'd0, 23'd0, 16'd0);
        // fill table to full and drop
        for (int i = 0; i < 34; i++) send(REQ_DET, 24'(i * 16), 24'd3, 32'd20);
        send(REQ_DET, 24'd0, 24'd3, 32'd20);
        send(REQ_FRAME, '0, '0, 32'd21);
        // long hold-off while sender keeps offering
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 6; i++) send(REQ_TARGET, 24'(i), 24'(i), 32'd0);
            end
            begin
                repeat (800) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
        drain_and_config(23'd614, 23'd1434, 16'd1000);
        for (int i = 0; i < 300; i++) random_request(3000, 200);
        drain_and_config(23'd4000, 23'd20000, 16'd50);
        for (int i = 0; i < 300; i++) random_request(20000, 30);
        drain_and_config(23'd100, 23'd300, 16'd5000);
        for (int i = 0; i < 300; i++) random_request(8000, 40);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
